// ===== rtl/core/avc_slice_header_parser_defines.svh =====
// ----------------------------------------------------------------------------
// avc slice header parser assertion macros
// check macros used by the slice header parser datapath
// ----------------------------------------------------------------------------
`ifndef AVC_SLICE_HEADER_PARSER_DEFINES_SVH
`define AVC_SLICE_HEADER_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASHP_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ashp check failed");
`define ASHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ashp sequence check failed");
`else
`define ASHP_ASSERT(lbl, expr)
`define ASHP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/ashp_pkg.sv =====
// ----------------------------------------------------------------------------
// ashp_pkg
// types and constants of the slice header parser
// ----------------------------------------------------------------------------
package ashp_pkg;

	localparam int MAX_LOOP_ENTRIES = 32;
	localparam int MAX_CODE_BITS    = 32;
	localparam int BITS_PER_BYTE    = 8;

	localparam logic [5:0] E_FIRST_MB        = 6'd0;
	localparam logic [5:0] E_SLICE_TYPE      = 6'd1;
	localparam logic [5:0] E_PPS_ID          = 6'd2;
	localparam logic [5:0] E_COLOUR_PLANE    = 6'd3;
	localparam logic [5:0] E_FRAME_NUM       = 6'd4;
	localparam logic [5:0] E_FIELD_PIC       = 6'd5;
	localparam logic [5:0] E_BOTTOM_FIELD    = 6'd6;
	localparam logic [5:0] E_IDR_PIC_ID      = 6'd7;
	localparam logic [5:0] E_POC_LSB         = 6'd8;
	localparam logic [5:0] E_DPOC_BOTTOM     = 6'd9;
	localparam logic [5:0] E_DPOC0           = 6'd10;
	localparam logic [5:0] E_DPOC1           = 6'd11;
	localparam logic [5:0] E_REDUNDANT_CNT   = 6'd12;
	localparam logic [5:0] E_DIRECT_SPATIAL  = 6'd13;
	localparam logic [5:0] E_OVERRIDE_FLAG   = 6'd14;
	localparam logic [5:0] E_NUM_REF_L0      = 6'd15;
	localparam logic [5:0] E_NUM_REF_L1      = 6'd16;
	localparam logic [5:0] E_REORDER_L0      = 6'd17;
	localparam logic [5:0] E_REORDER_L1      = 6'd18;
	localparam logic [5:0] E_REORDER_IDC     = 6'd19;
	localparam logic [5:0] E_ABS_DIFF        = 6'd20;
	localparam logic [5:0] E_LT_PIC_REORD    = 6'd21;
	localparam logic [5:0] E_LUMA_DENOM      = 6'd22;
	localparam logic [5:0] E_CHROMA_DENOM    = 6'd23;
	localparam logic [5:0] E_L0_LUMA_FLAG    = 6'd24;
	localparam logic [5:0] E_L0_LUMA_W       = 6'd25;
	localparam logic [5:0] E_L0_LUMA_O       = 6'd26;
	localparam logic [5:0] E_L0_CHROMA_FLAG  = 6'd27;
	localparam logic [5:0] E_L0_CHROMA_W     = 6'd28;
	localparam logic [5:0] E_L0_CHROMA_O     = 6'd29;
	localparam logic [5:0] E_L1_LUMA_FLAG    = 6'd30;
	localparam logic [5:0] E_L1_LUMA_W       = 6'd31;
	localparam logic [5:0] E_L1_LUMA_O       = 6'd32;
	localparam logic [5:0] E_L1_CHROMA_FLAG  = 6'd33;
	localparam logic [5:0] E_L1_CHROMA_W     = 6'd34;
	localparam logic [5:0] E_L1_CHROMA_O     = 6'd35;
	localparam logic [5:0] E_NO_OUTPUT_PRIOR = 6'd36;
	localparam logic [5:0] E_LONG_TERM_REF   = 6'd37;
	localparam logic [5:0] E_ADAPTIVE_MARK   = 6'd38;
	localparam logic [5:0] E_MMCO            = 6'd39;
	localparam logic [5:0] E_DIFF_PIC_NUMS   = 6'd40;
	localparam logic [5:0] E_LT_PIC_MARK     = 6'd41;
	localparam logic [5:0] E_LT_FRAME_IDX    = 6'd42;
	localparam logic [5:0] E_MAX_LT_IDX      = 6'd43;
	localparam logic [5:0] E_CABAC_INIT      = 6'd44;
	localparam logic [5:0] E_QP_DELTA        = 6'd45;
	localparam logic [5:0] E_DONE            = 6'd46;
	localparam logic [5:0] E_ERROR           = 6'd47;

	localparam logic [2:0] CFG_FRAME_NUM_BITS = 3'd0;
	localparam logic [2:0] CFG_POC_TYPE       = 3'd1;
	localparam logic [2:0] CFG_POC_LSB_BITS   = 3'd2;
	localparam logic [2:0] CFG_CHROMA_FORMAT  = 3'd3;
	localparam logic [2:0] CFG_SEQ_FLAGS      = 3'd4;
	localparam logic [2:0] CFG_PIC_FLAGS      = 3'd5;
	localparam logic [2:0] CFG_BIPRED_MODE    = 3'd6;
	localparam logic [2:0] CFG_REF_COUNTS     = 3'd7;

	typedef struct packed {
		logic load;
		logic idr;
		logic nal_ref;
		logic step;
		logic bit_val;
		logic term;
		logic eob_err;
		logic flush;
	} ashp_cmd_t;

	typedef struct packed {
		logic active;
		logic term_pending;
		logic bit_emits;
		logic can_push;
		logic hold_valid;
		logic out_free;
	} ashp_sts_t;

	typedef struct packed {
		logic [5:0]  id;
		logic [32:0] value;
		logic [4:0]  lidx;
		logic        comp;
		logic        done;
		logic        err;
	} ashp_res_t;

endpackage

// ===== rtl/core/ashp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ashp_ctrl
// byte sequencer: takes a byte, walks its bits and drains the results
// ----------------------------------------------------------------------------
module ashp_ctrl import ashp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic [2:0] s_axis_tuser,
	input  logic       s_axis_tlast,
	input  ashp_sts_t  sts,
	output ashp_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BIT   = 2'd1;
	localparam logic [1:0] ST_END   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q, state_nxt;
	logic [7:0] byte_q;
	logic [3:0] cnt_q;
	logic       last_q;

	always_comb begin
		cmd = '0;
		cmd.bit_val = byte_q[7];
		cmd.idr = s_axis_tuser[1];
		cmd.nal_ref = s_axis_tuser[2];
		state_nxt = state_q;
		s_axis_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load = s_axis_tuser[0];
					state_nxt = ST_BIT;
				end
			end
			ST_BIT: begin
				if (sts.term_pending) begin
					cmd.term = sts.can_push;
				end else if (sts.active && cnt_q != 4'(BITS_PER_BYTE)) begin
					cmd.step = !sts.bit_emits || sts.can_push;
				end else begin
					state_nxt = ST_END;
				end
			end
			ST_END: begin
				if (last_q && sts.active) begin
					if (sts.can_push) begin
						cmd.eob_err = 1'b1;
						state_nxt = ST_FLUSH;
					end
				end else begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.hold_valid) begin
					state_nxt = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (s_axis_tvalid && s_axis_tready) begin
				cnt_q <= '0;
				last_q <= s_axis_tlast;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_q <= s_axis_tdata;
		end else if (cmd.step) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
	end

endmodule

// ===== rtl/core/ashp_dpath.sv =====
// ----------------------------------------------------------------------------
// ashp_dpath
// code assembler, syntax state, slice values, settings and result staging
// ----------------------------------------------------------------------------
`include "avc_slice_header_parser_defines.svh"

module ashp_dpath import ashp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  ashp_cmd_t   cmd,
	output ashp_sts_t   sts,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam logic [31:0] IDC_ADD         = 32'd1;
	localparam logic [31:0] IDC_LONG        = 32'd2;
	localparam logic [31:0] IDC_END         = 32'd3;
	localparam logic [31:0] MMCO_END        = 32'd0;
	localparam logic [31:0] MMCO_UNMARK_ST  = 32'd1;
	localparam logic [31:0] MMCO_UNMARK_LT  = 32'd2;
	localparam logic [31:0] MMCO_ST_TO_LT   = 32'd3;
	localparam logic [31:0] MMCO_MAX_LT     = 32'd4;
	localparam logic [31:0] MMCO_CUR_LT     = 32'd6;
	localparam logic [2:0]  MMCO_CLAMP      = 3'd7;
	localparam logic [31:0] SLICE_TYPE_MAX  = 32'd9;
	localparam logic [31:0] REF_COUNT_MAX   = 32'd31;
	localparam logic [2:0]  KIND_P          = 3'd0;
	localparam logic [2:0]  KIND_B          = 3'd1;
	localparam logic [2:0]  KIND_SP         = 3'd3;
	localparam logic [1:0]  POC_EXPLICIT    = 2'd0;
	localparam logic [1:0]  POC_DELTA       = 2'd1;
	localparam logic [1:0]  BIPRED_EXPLICIT = 2'd1;
	localparam logic [5:0]  COLOUR_BITS     = 6'd2;
	localparam logic [5:0]  BASE_BITS       = 6'd4;

	// settings
	logic [3:0] fnb_q, plb_q, picf_q;
	logic [1:0] poc_q, chroma_q, bip_q;
	logic [2:0] seqf_q;
	logic [9:0] defc_q;

	// parser state
	logic [5:0]  syntax_q, zc_q, pend_q;
	logic [31:0] shift_q;
	logic [2:0]  kind_q, opc_q;
	logic        field_q, inner_q, term_q;
	logic [9:0]  ovr_q;
	logic [4:0]  loop_q;
	logic [1:0]  idrref_q;

	// result staging
	ashp_res_t hold_q, out_q, res;
	logic      hold_v_q, out_v_q, out_last_q, push, out_free;

	logic        fixed, se, complete, overlong, kb, ki, chroma_on, lsel, start_l;
	logic        go_next, go_end, go_start;
	logic [31:0] sh_next, ushift, code, n_shift;
	logic [5:0]  pend_dec, zc_inc, n_pend, n_zc, nxt, next_first;
	logic [32:0] mag, sval;
	logic [2:0]  n_kind, n_opc;
	logic        n_field, n_inner;
	logic [9:0]  n_ovr;
	logic [4:0]  n_loop, lm_end, lm_start;
	logic [6:0]  loop_inc;

	function automatic logic is_fixed(input logic [5:0] id);
		case (id)
			E_COLOUR_PLANE, E_FRAME_NUM, E_FIELD_PIC, E_BOTTOM_FIELD, E_POC_LSB,
			E_DIRECT_SPATIAL, E_OVERRIDE_FLAG, E_REORDER_L0, E_REORDER_L1,
			E_L0_LUMA_FLAG, E_L0_CHROMA_FLAG, E_L1_LUMA_FLAG, E_L1_CHROMA_FLAG,
			E_NO_OUTPUT_PRIOR, E_LONG_TERM_REF, E_ADAPTIVE_MARK: is_fixed = 1'b1;
			default: is_fixed = 1'b0;
		endcase
	endfunction

	function automatic logic is_se(input logic [5:0] id);
		case (id)
			E_DPOC_BOTTOM, E_DPOC0, E_DPOC1, E_L0_LUMA_W, E_L0_LUMA_O, E_L0_CHROMA_W,
			E_L0_CHROMA_O, E_L1_LUMA_W, E_L1_LUMA_O, E_L1_CHROMA_W, E_L1_CHROMA_O,
			E_QP_DELTA: is_se = 1'b1;
			default: is_se = 1'b0;
		endcase
	endfunction

	function automatic logic [5:0] fixed_width(input logic [5:0] id);
		case (id)
			E_COLOUR_PLANE: fixed_width = COLOUR_BITS;
			E_FRAME_NUM: fixed_width = {2'b0, fnb_q} + BASE_BITS;
			E_POC_LSB: fixed_width = {2'b0, plb_q} + BASE_BITS;
			default: fixed_width = {5'b0, is_fixed(id)};
		endcase
	endfunction

	function automatic logic [5:0] seek(input logic [5:0] from);
		if (from <= E_COLOUR_PLANE && seqf_q[2]) seek = E_COLOUR_PLANE;
		else if (from <= E_FRAME_NUM) seek = E_FRAME_NUM;
		else if (from <= E_FIELD_PIC && !seqf_q[0]) seek = E_FIELD_PIC;
		else if (from <= E_IDR_PIC_ID && idrref_q[0]) seek = E_IDR_PIC_ID;
		else if (from <= E_POC_LSB && poc_q == POC_EXPLICIT) seek = E_POC_LSB;
		else if (from <= E_DPOC0 && poc_q == POC_DELTA && !seqf_q[1]) seek = E_DPOC0;
		else if (from <= E_REDUNDANT_CNT && picf_q[1]) seek = E_REDUNDANT_CNT;
		else if (from <= E_DIRECT_SPATIAL && kb) seek = E_DIRECT_SPATIAL;
		else if (from <= E_OVERRIDE_FLAG && ki) seek = E_OVERRIDE_FLAG;
		else if (from <= E_REORDER_L0 && ki) seek = E_REORDER_L0;
		else if (from <= E_REORDER_L1 && kb) seek = E_REORDER_L1;
		else if (from <= E_LUMA_DENOM && ((picf_q[2] && (kind_q == KIND_P || kind_q == KIND_SP))
				|| (bip_q == BIPRED_EXPLICIT && kb))) seek = E_LUMA_DENOM;
		else if (from <= E_NO_OUTPUT_PRIOR && idrref_q[1])
			seek = idrref_q[0] ? E_NO_OUTPUT_PRIOR : E_ADAPTIVE_MARK;
		else if (from <= E_CABAC_INIT && picf_q[3] && ki) seek = E_CABAC_INIT;
		else seek = E_QP_DELTA;
	endfunction

	assign kb = (kind_q == KIND_B);
	assign ki = (kind_q == KIND_P) || (kind_q == KIND_B) || (kind_q == KIND_SP);
	assign chroma_on = (chroma_q != 2'd0) && !seqf_q[2];

	// code assembler
	always_comb begin
		fixed = is_fixed(syntax_q);
		se = is_se(syntax_q);
		sh_next = {shift_q[30:0], cmd.bit_val};
		pend_dec = pend_q - 6'd1;
		zc_inc = zc_q + 6'd1;
		complete = 1'b0;
		overlong = 1'b0;
		ushift = '0;
		code = '0;
		n_shift = shift_q;
		n_pend = pend_q;
		n_zc = zc_q;
		if (fixed) begin
			n_shift = sh_next;
			n_pend = pend_dec;
			if (pend_dec == 6'd0) begin
				complete = 1'b1;
				code = sh_next;
			end
		end else if (pend_q == 6'd0) begin
			if (!cmd.bit_val) begin
				n_zc = zc_inc;
				overlong = (zc_inc >= 6'(MAX_CODE_BITS));
			end else if (zc_q == 6'd0) begin
				complete = 1'b1;
				ushift = 32'd1;
			end else begin
				n_shift = 32'd1;
				n_pend = zc_q;
			end
		end else begin
			n_shift = sh_next;
			n_pend = pend_dec;
			if (pend_dec == 6'd0) begin
				complete = 1'b1;
				ushift = sh_next;
				code = sh_next - 32'd1;
			end
		end
		mag = {2'b0, ushift[31:1]};
		sval = ushift[0] ? -mag : mag;
	end

	// next element
	always_comb begin
		n_kind = kind_q;
		n_field = field_q;
		n_ovr = ovr_q;
		n_loop = loop_q;
		n_inner = inner_q;
		n_opc = opc_q;
		nxt = E_ERROR;
		go_next = 1'b0;
		go_end = 1'b0;
		go_start = 1'b0;
		start_l = 1'b0;
		next_first = E_REORDER_IDC;
		lsel = (syntax_q >= E_L1_LUMA_FLAG);
		loop_inc = {2'b0, loop_q} + 7'd1;
		lm_end = lsel ? ovr_q[9:5] : ovr_q[4:0];
		case (syntax_q)
			E_FIRST_MB: nxt = E_SLICE_TYPE;
			E_SLICE_TYPE: begin
				if (code <= SLICE_TYPE_MAX) begin
					n_kind = (code[3:0] >= 4'd5) ? 3'(code[3:0] - 4'd5) : code[2:0];
					nxt = E_PPS_ID;
				end
			end
			E_FIELD_PIC: begin
				n_field = code[0];
				nxt = code[0] ? E_BOTTOM_FIELD : seek(E_IDR_PIC_ID);
			end
			E_POC_LSB: nxt = (picf_q[0] && !field_q) ? E_DPOC_BOTTOM : seek(E_DPOC0);
			E_DPOC0: nxt = (picf_q[0] && !field_q) ? E_DPOC1 : seek(E_REDUNDANT_CNT);
			E_OVERRIDE_FLAG: begin
				n_ovr = defc_q;
				nxt = code[0] ? E_NUM_REF_L0 : seek(E_REORDER_L0);
			end
			E_NUM_REF_L0: begin
				if (code <= REF_COUNT_MAX) begin
					n_ovr = {ovr_q[9:5], code[4:0]};
					nxt = kb ? E_NUM_REF_L1 : seek(E_REORDER_L0);
				end
			end
			E_NUM_REF_L1: begin
				if (code <= REF_COUNT_MAX) begin
					n_ovr = {code[4:0], ovr_q[4:0]};
					nxt = seek(E_REORDER_L0);
				end
			end
			E_REORDER_L0, E_REORDER_L1: begin
				n_opc = (syntax_q == E_REORDER_L1) ? 3'd1 : 3'd0;
				n_loop = '0;
				if (code[0]) nxt = E_REORDER_IDC;
				else nxt = seek((syntax_q == E_REORDER_L0) ? E_REORDER_L1 : E_LUMA_DENOM);
			end
			E_REORDER_IDC: begin
				if (code <= IDC_ADD) nxt = E_ABS_DIFF;
				else if (code == IDC_LONG) nxt = E_LT_PIC_REORD;
				else if (code == IDC_END)
					nxt = (opc_q == 3'd0) ? seek(E_REORDER_L1) : seek(E_LUMA_DENOM);
				else go_next = 1'b1;
			end
			E_ABS_DIFF, E_LT_PIC_REORD: go_next = 1'b1;
			E_LUMA_DENOM: begin
				if (chroma_on) nxt = E_CHROMA_DENOM;
				else go_start = 1'b1;
			end
			E_CHROMA_DENOM: go_start = 1'b1;
			E_L0_LUMA_FLAG, E_L1_LUMA_FLAG: begin
				if (code[0]) nxt = syntax_q + 6'd1;
				else if (chroma_on) nxt = lsel ? E_L1_CHROMA_FLAG : E_L0_CHROMA_FLAG;
				else go_end = 1'b1;
			end
			E_L0_LUMA_W, E_L1_LUMA_W, E_L0_CHROMA_W, E_L1_CHROMA_W: nxt = syntax_q + 6'd1;
			E_L0_LUMA_O, E_L1_LUMA_O: begin
				if (chroma_on) nxt = lsel ? E_L1_CHROMA_FLAG : E_L0_CHROMA_FLAG;
				else go_end = 1'b1;
			end
			E_L0_CHROMA_FLAG, E_L1_CHROMA_FLAG: begin
				n_inner = 1'b0;
				if (code[0]) nxt = syntax_q + 6'd1;
				else go_end = 1'b1;
			end
			E_L0_CHROMA_O, E_L1_CHROMA_O: begin
				if (!inner_q) begin
					n_inner = 1'b1;
					nxt = lsel ? E_L1_CHROMA_W : E_L0_CHROMA_W;
				end else begin
					go_end = 1'b1;
				end
			end
			E_NO_OUTPUT_PRIOR: nxt = E_LONG_TERM_REF;
			E_LONG_TERM_REF: nxt = seek(E_CABAC_INIT);
			E_ADAPTIVE_MARK: begin
				n_loop = '0;
				nxt = code[0] ? E_MMCO : seek(E_CABAC_INIT);
			end
			E_MMCO: begin
				n_opc = (code > MMCO_CUR_LT) ? MMCO_CLAMP : code[2:0];
				next_first = E_MMCO;
				if (code == MMCO_END) nxt = seek(E_CABAC_INIT);
				else if (code == MMCO_UNMARK_ST || code == MMCO_ST_TO_LT) nxt = E_DIFF_PIC_NUMS;
				else if (code == MMCO_UNMARK_LT) nxt = E_LT_PIC_MARK;
				else if (code == MMCO_CUR_LT) nxt = E_LT_FRAME_IDX;
				else if (code == MMCO_MAX_LT) nxt = E_MAX_LT_IDX;
				else go_next = 1'b1;
			end
			E_DIFF_PIC_NUMS: begin
				next_first = E_MMCO;
				if ({29'd0, opc_q} == MMCO_ST_TO_LT) nxt = E_LT_FRAME_IDX;
				else go_next = 1'b1;
			end
			E_LT_PIC_MARK, E_LT_FRAME_IDX, E_MAX_LT_IDX: begin
				next_first = E_MMCO;
				go_next = 1'b1;
			end
			E_CABAC_INIT: nxt = E_QP_DELTA;
			E_QP_DELTA: nxt = E_DONE;
			default: nxt = seek(syntax_q + 6'd1);
		endcase
		if (go_next) begin
			n_loop = loop_inc[4:0];
			nxt = (loop_inc >= 7'(MAX_LOOP_ENTRIES)) ? E_ERROR : next_first;
		end
		if (go_end) begin
			n_loop = loop_inc[4:0];
			n_inner = 1'b0;
			if (loop_inc > {2'b0, lm_end}) begin
				if (!lsel && kb) begin
					go_start = 1'b1;
					start_l = 1'b1;
				end else begin
					nxt = seek(E_NO_OUTPUT_PRIOR);
				end
			end else begin
				nxt = lsel ? E_L1_LUMA_FLAG : E_L0_LUMA_FLAG;
			end
		end
		lm_start = start_l ? ovr_q[9:5] : ovr_q[4:0];
		if (go_start) begin
			if ({2'b0, lm_start} >= 7'(MAX_LOOP_ENTRIES)) begin
				nxt = E_ERROR;
			end else begin
				n_loop = '0;
				n_inner = 1'b0;
				nxt = start_l ? E_L1_LUMA_FLAG : E_L0_LUMA_FLAG;
			end
		end
	end

	// result word
	always_comb begin
		res = '0;
		if (cmd.term) begin
			res.id = syntax_q;
			res.done = (syntax_q == E_DONE);
			res.err = (syntax_q == E_ERROR);
		end else if (cmd.eob_err || overlong) begin
			res.id = E_ERROR;
			res.err = 1'b1;
		end else begin
			res.id = syntax_q;
			res.value = (!fixed && se) ? sval : {1'b0, code};
			if ((syntax_q >= E_REORDER_IDC && syntax_q <= E_LT_PIC_REORD)
					|| (syntax_q >= E_L0_LUMA_FLAG && syntax_q <= E_L1_CHROMA_O)
					|| (syntax_q >= E_MMCO && syntax_q <= E_MAX_LT_IDX))
				res.lidx = loop_q;
			if (syntax_q == E_L0_CHROMA_W || syntax_q == E_L0_CHROMA_O
					|| syntax_q == E_L1_CHROMA_W || syntax_q == E_L1_CHROMA_O)
				res.comp = inner_q;
		end
	end

	assign out_free = !out_v_q || m_axis_tready;
	assign push = (cmd.step && (complete || overlong)) || cmd.term || cmd.eob_err;

	assign sts.active = (syntax_q < E_DONE);
	assign sts.term_pending = term_q;
	assign sts.bit_emits = complete || overlong;
	assign sts.can_push = !hold_v_q || out_free;
	assign sts.hold_valid = hold_v_q;
	assign sts.out_free = out_free;

	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {3'b0, out_q.comp, out_q.lidx, out_q.value, out_q.id};
	assign m_axis_tuser = {out_q.err, out_q.done};
	assign m_axis_tlast = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnb_q <= '0;
			poc_q <= '0;
			plb_q <= '0;
			chroma_q <= 2'd1;
			seqf_q <= 3'd1;
			picf_q <= '0;
			bip_q <= '0;
			defc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_NUM_BITS: fnb_q <= cfg_data[3:0];
				CFG_POC_TYPE: poc_q <= cfg_data[1:0];
				CFG_POC_LSB_BITS: plb_q <= cfg_data[3:0];
				CFG_CHROMA_FORMAT: chroma_q <= cfg_data[1:0];
				CFG_SEQ_FLAGS: seqf_q <= cfg_data[2:0];
				CFG_PIC_FLAGS: picf_q <= cfg_data[3:0];
				CFG_BIPRED_MODE: bip_q <= cfg_data[1:0];
				CFG_REF_COUNTS: defc_q <= cfg_data;
				default: defc_q <= defc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syntax_q <= E_FIRST_MB;
			shift_q <= '0;
			zc_q <= '0;
			pend_q <= '0;
			kind_q <= '0;
			field_q <= 1'b0;
			ovr_q <= '0;
			loop_q <= '0;
			inner_q <= 1'b0;
			opc_q <= '0;
			idrref_q <= '0;
			term_q <= 1'b0;
		end else if (cmd.load) begin
			syntax_q <= E_FIRST_MB;
			shift_q <= '0;
			zc_q <= '0;
			pend_q <= fixed_width(E_FIRST_MB);
			kind_q <= '0;
			field_q <= 1'b0;
			ovr_q <= '0;
			loop_q <= '0;
			inner_q <= 1'b0;
			opc_q <= '0;
			idrref_q <= {cmd.nal_ref, cmd.idr};
			term_q <= 1'b0;
		end else if (cmd.step) begin
			if (overlong) begin
				syntax_q <= E_ERROR;
				zc_q <= n_zc;
			end else if (complete) begin
				kind_q <= n_kind;
				field_q <= n_field;
				ovr_q <= n_ovr;
				loop_q <= n_loop;
				inner_q <= n_inner;
				opc_q <= n_opc;
				syntax_q <= nxt;
				if (nxt == E_ERROR || nxt == E_DONE) begin
					term_q <= 1'b1;
					shift_q <= n_shift;
					pend_q <= n_pend;
					zc_q <= n_zc;
				end else begin
					shift_q <= '0;
					zc_q <= '0;
					pend_q <= fixed_width(nxt);
				end
			end else begin
				shift_q <= n_shift;
				pend_q <= n_pend;
				zc_q <= n_zc;
			end
		end else if (cmd.term) begin
			term_q <= 1'b0;
		end else if (cmd.eob_err) begin
			syntax_q <= E_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (push) hold_v_q <= 1'b1;
			else if (cmd.flush) hold_v_q <= 1'b0;
			if ((push && hold_v_q) || cmd.flush) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_q <= res;
			if (hold_v_q) begin
				out_q <= hold_q;
				out_last_q <= 1'b0;
			end
		end else if (cmd.flush) begin
			out_q <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	`ASHP_ASSERT(a_no_overwrite, !(push && hold_v_q && !out_free))
	`ASHP_ASSERT(a_step_active, !cmd.step || syntax_q < E_DONE)
	`ASHP_ASSERT(a_term_state, !term_q || syntax_q >= E_DONE)
	`ASHP_ASSERT_NEXT(a_stop_holds, syntax_q >= E_DONE && !cmd.load, syntax_q == $past(syntax_q))

endmodule

// ===== rtl/core/avc_slice_header_parser.sv =====
// ----------------------------------------------------------------------------
// avc_slice_header_parser
// slice header decoder for slice rbsp bytes, tagged element output
// ----------------------------------------------------------------------------
// input stream: one rbsp byte per word, tuser = first byte, idr, reference
// flags, tlast = last available byte. a first byte restarts the header.
// output stream: one decoded element per word, tuser flags done and error,
// tlast marks the final word caused by an input byte.
// config port: register index and data, always ready, write while idle.
// when nothing stalls a byte is accepted, its eight bits are walked
// through the serial code assembler, the bit walk is left, then come
// the end check and a result flush. once the header is finished or failed
// the bit walk stops early. a done marker, or an error raised by a
// completed element, is pushed as a result of its own. the next byte is
// accepted only after the previous byte's results are staged, the last
// one waits in the output register while the next byte is decoded.
// a stalled receiver holds the output register and the bit walk waits
// as soon as a new result has no place to go.
// reset returns the settings to their defaults and the parser to the
// start of the header, with idr and reference clear.
// ----------------------------------------------------------------------------
module avc_slice_header_parser import ashp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rbsp_byte
	input  logic [2:0]  s_axis_tuser,  // first_byte, nal_is_idr, nal_is_reference
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // element_id, element_value, list_index, component_index
	output logic [1:0]  m_axis_tuser,  // header_done, error
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	ashp_cmd_t cmd;
	ashp_sts_t sts;

	ashp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.sts           (sts),
		.cmd           (cmd)
	);

	ashp_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
